// ===== src/thrt_pkg.sv =====
// Package for the TLS handshake record tracker.
// Holds the phase and event codes, the record constants and the result word type.
// No dependencies.
package thrt_pkg;

  // Default number of skipped records after which the tracker forces active.
  localparam int SKIP_LIMIT_DEF = 10;

  localparam logic [7:0]  REC_HANDSHAKE   = 8'h16;
  localparam logic [7:0]  REC_CCS         = 8'h14;
  localparam logic [7:0]  HS_SERVER_HELLO = 8'h02;
  localparam logic [15:0] HELLO_MIN_LEN   = 16'd38;
  localparam logic [2:0]  HDR_LEN         = 3'd5;
  localparam logic [3:0]  SKIP_CNT_MAX    = 4'hF;

  // Header byte positions.
  localparam logic [2:0] HDR_TYPE_POS   = 3'd0;
  localparam logic [2:0] HDR_LEN_HI_POS = 3'd3;
  localparam logic [2:0] HDR_LEN_LO_POS = 3'd4;

  typedef enum logic [2:0] {
    PH_HELLO  = 3'd0,
    PH_SKIP   = 3'd1,
    PH_FIN    = 3'd2,
    PH_ACTIVE = 3'd3,
    PH_ERROR  = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_FINISHED = 2'd1,
    EV_FALLBACK = 2'd2,
    EV_MISMATCH = 2'd3
  } event_e;

  // One result word as it leaves the tracker core.
  typedef struct packed {
    phase_e phase;
    event_e event_res;
    logic   record_done;
  } res_t;

endpackage

// ===== src/thrt_core.sv =====
// Record framing and handshake phase machine of the TLS record tracker.
// Updates its state on each accepted byte and produces that byte's result word.
// Depends on thrt_pkg.
module thrt_core import thrt_pkg::*; #(
  parameter int SKIP_LIMIT = SKIP_LIMIT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        accept_i,
  input  logic [7:0]  rx_byte_i,
  output res_t        res_o
);

  logic [31:0] tag_q;
  phase_e      phase_q, phase_d;
  logic [2:0]  hdr_cnt_q, hdr_cnt_d;
  logic [7:0]  rec_type_q, rec_type_d;
  logic [15:0] rec_len_q, rec_len_d;
  logic [15:0] offset_q, offset_d;
  logic        hello_ok_q, hello_ok_d;
  logic        tag_match_q, tag_match_d;
  logic [3:0]  skip_cnt_q, skip_cnt_d;

  logic        done;
  logic [7:0]  want_byte;
  logic        tag_pos;
  logic [15:0] offset_inc;

  assign offset_inc = offset_q + 16'd1;
  assign tag_pos    = (offset_q >= 16'd6) && (offset_q <= 16'd9);

  // Tag byte 6 of the payload compares with the top byte of the tag.
  always_comb begin
    case (offset_q[1:0])
      2'b10:   want_byte = tag_q[31:24];
      2'b11:   want_byte = tag_q[23:16];
      2'b00:   want_byte = tag_q[15:8];
      default: want_byte = tag_q[7:0];
    endcase
  end

  // Framing: header capture and payload tracking.
  always_comb begin
    rec_type_d  = rec_type_q;
    rec_len_d   = rec_len_q;
    offset_d    = offset_q;
    hello_ok_d  = hello_ok_q;
    tag_match_d = tag_match_q;
    hdr_cnt_d   = hdr_cnt_q;
    done        = 1'b0;
    if (hdr_cnt_q < HDR_LEN) begin
      if (hdr_cnt_q == HDR_TYPE_POS) begin
        rec_type_d  = rx_byte_i;
        rec_len_d   = '0;
        offset_d    = '0;
        hello_ok_d  = 1'b0;
        tag_match_d = 1'b1;
      end else if (hdr_cnt_q == HDR_LEN_HI_POS) begin
        rec_len_d = {rx_byte_i, rec_len_q[7:0]};
      end else if (hdr_cnt_q == HDR_LEN_LO_POS) begin
        rec_len_d = {rec_len_q[15:8], rx_byte_i};
      end
      hdr_cnt_d = hdr_cnt_q + 3'd1;
      done      = (hdr_cnt_d == HDR_LEN) && (rec_len_d == '0);
    end else begin
      if (phase_q == PH_HELLO && rec_type_q == REC_HANDSHAKE) begin
        if (offset_q == '0) begin
          hello_ok_d = (rx_byte_i == HS_SERVER_HELLO);
        end else if (tag_pos && rx_byte_i != want_byte) begin
          tag_match_d = 1'b0;
        end
      end
      offset_d = offset_inc;
      done     = (offset_inc == rec_len_q);
    end
    if (done) begin
      hdr_cnt_d = '0;
      offset_d  = '0;
    end
  end

  // Phase machine: next phase and skip counter, acting only at record end.
  always_comb begin
    phase_d    = phase_q;
    skip_cnt_d = skip_cnt_q;
    if (done) begin
      case (phase_q)
        PH_HELLO: begin
          if (rec_type_d == REC_HANDSHAKE && hello_ok_d && rec_len_d >= HELLO_MIN_LEN) begin
            phase_d = tag_match_d ? PH_SKIP : PH_ERROR;
          end
        end
        PH_SKIP: begin
          if (skip_cnt_q < SKIP_CNT_MAX) begin
            skip_cnt_d = skip_cnt_q + 4'd1;
          end
          if (rec_type_d == REC_CCS) begin
            phase_d = PH_FIN;
          end else if (skip_cnt_d >= 4'(SKIP_LIMIT)) begin
            phase_d = PH_ACTIVE;
          end
        end
        PH_FIN:  phase_d = PH_ACTIVE;
        default: phase_d = phase_q;
      endcase
    end
  end

  // Result word for the current byte.
  always_comb begin
    res_o.phase       = phase_q;
    res_o.event_res   = EV_NONE;
    res_o.record_done = 1'b0;
    if (phase_q != PH_ACTIVE && phase_q != PH_ERROR) begin
      res_o.phase       = phase_d;
      res_o.record_done = done;
      if (phase_d == PH_ERROR) begin
        res_o.event_res = EV_MISMATCH;
      end else if (phase_d == PH_ACTIVE) begin
        res_o.event_res = (phase_q == PH_FIN) ? EV_FINISHED : EV_FALLBACK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else if (cfg_we_i) begin
      tag_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HELLO;
      hdr_cnt_q   <= '0;
      rec_type_q  <= '0;
      rec_len_q   <= '0;
      offset_q    <= '0;
      hello_ok_q  <= 1'b0;
      tag_match_q <= 1'b1;
      skip_cnt_q  <= '0;
    end else if (accept_i && phase_q != PH_ACTIVE && phase_q != PH_ERROR) begin
      phase_q     <= phase_d;
      hdr_cnt_q   <= hdr_cnt_d;
      rec_type_q  <= rec_type_d;
      rec_len_q   <= rec_len_d;
      offset_q    <= offset_d;
      hello_ok_q  <= hello_ok_d;
      tag_match_q <= tag_match_d;
      skip_cnt_q  <= skip_cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_ERROR |=> phase_q == PH_ERROR)
    else $error("error phase was left");

  a_active_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_ACTIVE |=> phase_q == PH_ACTIVE)
    else $error("active phase was left");

  a_hdr_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_cnt_q <= HDR_LEN)
    else $error("header byte count out of range");

  a_event_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && res_o.event_res != EV_NONE |-> res_o.record_done)
    else $error("event reported on a byte that does not end a record");
`endif

endmodule

// ===== src/thrt_out_buf.sv =====
// Two-entry result buffer of the TLS record tracker.
// Decouples input from output stall: a byte can enter every cycle while not full.
// Depends on thrt_pkg.
module thrt_out_buf import thrt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t data_i,
  output logic full_o,
  output logic valid_o,
  input  logic stall_i,
  output res_t data_o
);

  res_t       mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wr_ptr_q, rd_ptr_q;
  logic       pop;

  assign pop     = valid_o && !stall_i;
  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into a full result buffer");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2)
    else $error("result buffer count out of range");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) == (wr_ptr_q != rd_ptr_q))
    else $error("result buffer pointers disagree with count");
`endif

endmodule

// ===== src/tls_handshake_record_tracker.sv =====
// TLS handshake record tracker: one received byte per word in, one result word out.
// Each result word is written to the two-entry result buffer when its byte is accepted;
// it keeps bytes flowing while one result waits for the sink. Throughput: one byte per
// cycle unless the buffer is full; the whole update is one pass through the core logic.
// Reset (asynchronous, active low) returns to awaiting the server hello, clears the tag
// register and empties the result buffer; no clearing pass is needed.
module tls_handshake_record_tracker import thrt_pkg::*; #(
  parameter int SKIP_LIMIT = SKIP_LIMIT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: the expected four tag bytes, big-endian.
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  // Received byte stream.
  input  logic        rx_valid_i,
  output logic        rx_stall_o,
  input  logic [7:0]  rx_byte_i,
  // Result stream, one word per received byte.
  output logic        res_valid_o,
  input  logic        res_stall_i,
  output logic [2:0]  phase_o,
  output logic [1:0]  event_res_o,
  output logic        record_done_o
);

  logic rx_accept;
  logic buf_full;
  res_t core_res;
  res_t out_res;

  // A byte is taken whenever the result buffer has room; the stall is a
  // registered condition and never depends on the sink's stall in the same cycle.
  assign rx_stall_o = buf_full;
  assign rx_accept  = rx_valid_i && !buf_full;

  // The core frames records and runs the phase machine. Its result for the
  // current byte is ready in the same cycle, and its state advances at the
  // edge that accepts the byte.
  thrt_core #(
    .SKIP_LIMIT(SKIP_LIMIT)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (rx_accept),
    .rx_byte_i  (rx_byte_i),
    .res_o      (core_res)
  );

  // The result buffer holds up to two words so that a byte can still be taken
  // while the sink stalls on the word ahead of it.
  thrt_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (rx_accept),
    .data_i (core_res),
    .full_o (buf_full),
    .valid_o(res_valid_o),
    .stall_i(res_stall_i),
    .data_o (out_res)
  );

  assign phase_o       = out_res.phase;
  assign event_res_o   = out_res.event_res;
  assign record_done_o = out_res.record_done;

`ifndef SYNTHESIS
  a_done_on_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && event_res_o != EV_NONE |-> record_done_o)
    else $error("event word without record end");

  a_mismatch_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && event_res_o == EV_MISMATCH |-> phase_o == PH_ERROR)
    else $error("tag mismatch reported outside the error phase");

  a_active_events: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (event_res_o == EV_FINISHED || event_res_o == EV_FALLBACK)
      |-> phase_o == PH_ACTIVE)
    else $error("activation event without active phase");
`endif

endmodule

// ===== sim/tls_handshake_record_tracker_tb.sv =====
// Self-checking testbench for the TLS handshake record tracker.
// Drives a byte stream of TLS records and checks every result word against a scoreboard.
// Depends on thrt_pkg and tls_handshake_record_tracker.
module tls_handshake_record_tracker_tb;
  import thrt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SKIP_LIMIT = SKIP_LIMIT_DEF;
  // The run is far shorter than this; it only catches a hung handshake.
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  // How the one decisive server hello ends the run of the phase machine.
  localparam int PATH_MISMATCH = 0;
  localparam int PATH_FINISHED = 1;
  localparam int PATH_FALLBACK = 2;

  // The scoreboard keeps its own copy of the tracker state and predicts one result
  // word for every byte the tracker accepts.
  class phase_scoreboard;
    phase_e      cur_phase = PH_HELLO;
    logic [2:0]  hdr_seen = '0;
    logic [7:0]  rec_type = '0;
    logic [15:0] rec_len = '0;
    logic [15:0] body_seen = '0;
    logic        hello_ok = 1'b0;
    logic        tag_ok = 1'b1;
    logic [3:0]  skipped = '0;
    logic [31:0] tag = '0;
    res_t        expected_words[$];
    int unsigned mismatch_count = 0;

    function void note_byte(logic [7:0] b);
      res_t   want;
      logic   done;
      event_e ev;
      int     sh;
      done = 1'b0;
      ev = EV_NONE;
      if (cur_phase == PH_ACTIVE || cur_phase == PH_ERROR) begin
        // Terminal phases ignore the stream but still answer every byte.
        want.phase = cur_phase;
        want.event_res = EV_NONE;
        want.record_done = 1'b0;
        expected_words.push_back(want);
        return;
      end
      if (hdr_seen < HDR_LEN) begin
        case (hdr_seen)
          HDR_TYPE_POS: begin
            rec_type = b;
            rec_len = '0;
            body_seen = '0;
            hello_ok = 1'b0;
            tag_ok = 1'b1;
          end
          HDR_LEN_HI_POS: rec_len[15:8] = b;
          HDR_LEN_LO_POS: rec_len[7:0] = b;
          default: ;
        endcase
        hdr_seen++;
        // An empty record ends on its last header byte.
        if (hdr_seen == HDR_LEN && rec_len == 16'd0) done = 1'b1;
      end else begin
        if (cur_phase == PH_HELLO && rec_type == REC_HANDSHAKE) begin
          if (body_seen == 16'd0) begin
            hello_ok = (b == HS_SERVER_HELLO);
          end else if (body_seen >= 16'd6 && body_seen <= 16'd9) begin
            // The tag byte is compared with the register as it stands right now.
            sh = 8 * (9 - int'(body_seen));
            if (b != tag[sh +: 8]) tag_ok = 1'b0;
          end
        end
        body_seen = body_seen + 16'd1;
        if (body_seen == rec_len) done = 1'b1;
      end
      if (done) begin
        case (cur_phase)
          PH_HELLO: begin
            if (rec_type == REC_HANDSHAKE && hello_ok && rec_len >= HELLO_MIN_LEN) begin
              if (tag_ok) begin
                cur_phase = PH_SKIP;
              end else begin
                cur_phase = PH_ERROR;
                ev = EV_MISMATCH;
              end
            end
          end
          PH_SKIP: begin
            if (skipped != SKIP_CNT_MAX) skipped++;
            if (rec_type == REC_CCS) begin
              cur_phase = PH_FIN;
            end else if (skipped >= SKIP_LIMIT) begin
              cur_phase = PH_ACTIVE;
              ev = EV_FALLBACK;
            end
          end
          PH_FIN: begin
            cur_phase = PH_ACTIVE;
            ev = EV_FINISHED;
          end
          default: ;
        endcase
        hdr_seen = '0;
        body_seen = '0;
      end
      want.phase = cur_phase;
      want.event_res = ev;
      want.record_done = done;
      expected_words.push_back(want);
    endfunction

    function void check_word(logic [2:0] phase, logic [1:0] ev, logic done);
      res_t want;
      if (expected_words.size() == 0) begin
        $error("result word with no byte waiting: phase %0d event_res %0d record_done %0d",
               phase, ev, done);
        mismatch_count++;
        return;
      end
      want = expected_words.pop_front();
      if (phase !== want.phase) begin
        $error("phase: expected %0d, got %0d", want.phase, phase);
        mismatch_count++;
      end
      if (ev !== want.event_res) begin
        $error("event_res: expected %0d, got %0d", want.event_res, ev);
        mismatch_count++;
      end
      if (done !== want.record_done) begin
        $error("record_done: expected %0d, got %0d", want.record_done, done);
        mismatch_count++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic        rx_valid_i;
  logic        rx_stall_o;
  logic [7:0]  rx_byte_i;
  logic        res_valid_o;
  logic        res_stall_i;
  logic [2:0]  phase_o;
  logic [1:0]  event_res_o;
  logic        record_done_o;

  phase_scoreboard sb;
  int unsigned     bytes_sent = 0;
  int unsigned     calm_left = 0;
  int unsigned     cycle_count = 0;
  int unsigned     stall_left = 0;
  int unsigned     stall_mode = 0;

  tls_handshake_record_tracker #(
    .SKIP_LIMIT(SKIP_LIMIT)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .rx_valid_i   (rx_valid_i),
    .rx_stall_o   (rx_stall_o),
    .rx_byte_i    (rx_byte_i),
    .res_valid_o  (res_valid_o),
    .res_stall_i  (res_stall_i),
    .phase_o      (phase_o),
    .event_res_o  (event_res_o),
    .record_done_o(record_done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a correct run finishes long before this.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side. Every word taken at this edge is checked, then the stall for the
  // next cycle is chosen. Stall behavior comes in stretches: free flow, random
  // stalling, or a long solid stall that fills the tracker's result buffer.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o && !res_stall_i) sb.check_word(phase_o, event_res_o, record_done_o);
    if (stall_left == 0) begin
      stall_left = $urandom_range(0, 99);
      if (stall_left < 40) begin
        stall_mode = 0;
        stall_left = $urandom_range(10, 60);
      end else if (stall_left < 95) begin
        stall_mode = 1;
        stall_left = $urandom_range(10, 40);
      end else begin
        stall_mode = 2;
        stall_left = $urandom_range(5, 40);
      end
    end else begin
      stall_left--;
    end
    res_stall_i <= (stall_mode == 2) || (stall_mode == 1 && $urandom_range(0, 2) == 0);
  end

  // Offers one byte and returns at the edge where the tracker takes it. A random gap
  // comes first, now and then replaced by a calm stretch of back-to-back words.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    int unsigned r;
    gap = 0;
    if (calm_left > 0) begin
      calm_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) calm_left = $urandom_range(20, 80);
      else if (r < 60) gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else if (r < 98) gap = $urandom_range(4, 10);
      else gap = $urandom_range(20, 50);
    end
    if (gap != 0) begin
      rx_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (rx_stall_o) @(posedge clk_i);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  // Drops valid and waits until every expected result word has come out.
  task automatic wait_drained();
    rx_valid_i <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk_i);
  endtask

  // The tag register is only written while the tracker has nothing in flight.
  task automatic write_tag(input logic [31:0] value);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.tag = value;
  endtask

  // Payload byte at a given offset: the handshake type first, the four tag bytes at
  // offsets 6..9 (big-endian), random filler elsewhere.
  function automatic logic [7:0] payload_byte(int p, logic [7:0] first, logic [31:0] tag_bytes);
    if (p == 0) return first;
    if (p >= 6 && p <= 9) return tag_bytes[8 * (9 - p) +: 8];
    return 8'($urandom);
  endfunction

  // A complete record: type, two random version bytes, big-endian length, payload.
  task automatic send_record(input logic [7:0] rec_type, input logic [15:0] len,
                             input logic [7:0] first, input logic [31:0] tag_bytes);
    send_byte(rec_type);
    send_byte(8'($urandom));
    send_byte(8'($urandom));
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    for (int p = 0; p < int'(len); p++) send_byte(payload_byte(p, first, tag_bytes));
  endtask

  // Records while awaiting the hello that must not settle the phase: any mix of
  // types, lengths and tag contents, but never a full-length server hello.
  task automatic send_noise(input int unsigned target);
    logic [7:0]  rec_type;
    logic [7:0]  first;
    logic [15:0] len;
    int unsigned r;
    while (bytes_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 45) rec_type = REC_HANDSHAKE;
      else if (r < 60) rec_type = REC_CCS;
      else rec_type = 8'($urandom);
      r = $urandom_range(0, 99);
      if (r < 60) len = 16'($urandom_range(0, 45));
      else if (r < 95) len = 16'($urandom_range(30, 60));
      else len = 16'($urandom_range(61, 400));
      first = $urandom_range(0, 1) ? HS_SERVER_HELLO : 8'($urandom);
      if (rec_type == REC_HANDSHAKE && first == HS_SERVER_HELLO && len >= HELLO_MIN_LEN)
        first = first ^ 8'($urandom_range(1, 255));
      send_record(rec_type, len, first, $urandom_range(0, 1) ? sb.tag : 32'($urandom));
    end
  endtask

  // A record counted while skipping; never a ChangeCipherSpec.
  task automatic send_skip_record();
    logic [7:0] rec_type;
    rec_type = 8'($urandom);
    if (rec_type == REC_CCS) rec_type = REC_HANDSHAKE;
    send_record(rec_type, 16'($urandom_range(0, 40)), 8'($urandom), 32'($urandom));
  endtask

  initial begin
    logic [31:0] old_tag;
    logic [31:0] new_tag;
    logic [31:0] sent_tag;
    logic [15:0] hello_len;
    int          path;
    sb = new;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    rx_valid_i = 1'b0;
    rx_byte_i = '0;
    res_stall_i = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed records while awaiting the hello, tag register at zero: an empty
    // record, a hello one byte too short, a long hello-shaped record of a foreign
    // type, a long handshake that is not a server hello, a lone ChangeCipherSpec,
    // and one record long enough to need the upper length byte.
    write_tag(32'h0000_0000);
    send_record(REC_HANDSHAKE, 16'd0, 8'h00, 32'h0);
    send_record(REC_HANDSHAKE, HELLO_MIN_LEN - 16'd1, HS_SERVER_HELLO, 32'h0);
    send_record(8'h17, HELLO_MIN_LEN, HS_SERVER_HELLO, 32'h0);
    send_record(REC_HANDSHAKE, HELLO_MIN_LEN, 8'h03, 32'h0);
    send_record(REC_CCS, 16'd1, 8'h01, 32'h0);
    send_record(8'hFF, 16'h0100, 8'hFF, 32'hFFFF_FFFF);

    // Random traffic in three phases with different tag settings.
    send_noise(bytes_sent + 60);
    write_tag(32'hFFFF_FFFF);
    send_record(REC_HANDSHAKE, HELLO_MIN_LEN - 16'd1, HS_SERVER_HELLO, 32'hFFFF_FFFF);
    send_noise(bytes_sent + 60);
    write_tag(32'($urandom));
    send_noise(bytes_sent + 60);

    // The decisive server hello. The register is rewritten after the first tag byte
    // has gone in, so that byte is judged by the old value and the other three by
    // the new one. On the mismatch path one bit of the sent tag is flipped.
    old_tag = sb.tag;
    new_tag = 32'($urandom);
    path = $urandom_range(PATH_MISMATCH, PATH_FALLBACK);
    hello_len = $urandom_range(0, 1) ? HELLO_MIN_LEN : 16'($urandom_range(39, 90));
    sent_tag = {old_tag[31:24], new_tag[23:0]};
    if (path == PATH_MISMATCH) sent_tag = sent_tag ^ (32'd1 << $urandom_range(0, 31));
    send_byte(REC_HANDSHAKE);
    send_byte(8'($urandom));
    send_byte(8'($urandom));
    send_byte(hello_len[15:8]);
    send_byte(hello_len[7:0]);
    for (int p = 0; p < int'(hello_len); p++) begin
      if (p == 7) write_tag(new_tag);
      send_byte(payload_byte(p, HS_SERVER_HELLO, sent_tag));
    end

    if (path == PATH_FINISHED) begin
      // Up to SKIP_LIMIT - 1 skipped records, so the ChangeCipherSpec may itself be
      // the record that reaches the limit; it still wins over the fallback.
      repeat ($urandom_range(0, SKIP_LIMIT - 1)) send_skip_record();
      send_record(REC_CCS, 16'd1, 8'h01, 32'($urandom));
      send_skip_record();
    end else if (path == PATH_FALLBACK) begin
      repeat (SKIP_LIMIT) send_skip_record();
    end

    // Active or error now: the rest of the stream must be ignored.
    repeat (40) send_byte(8'($urandom));

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (sb.mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/thrt_pkg.sv
src/thrt_core.sv
src/thrt_out_buf.sv
src/tls_handshake_record_tracker.sv
sim/tls_handshake_record_tracker_tb.sv
